@@ design/cpu6502_address_mode_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the 6502 addressing-mode unit
// Shared concurrent assertion forms, clocked on clk; AMU_ASSERT is gated by rst.
// ----------------------------------------------------------------------------
`ifndef CPU6502_ADDRESS_MODE_UNIT_MACROS_SVH
`define CPU6502_ADDRESS_MODE_UNIT_MACROS_SVH

// Property checked outside reset
`define AMU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property checked on every edge, reset included
`define AMU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ design/amu_pkg.sv @@
// ----------------------------------------------------------------------------
// amu_pkg
// Types, codes and result builders for the 6502 addressing-mode unit.
// ----------------------------------------------------------------------------
`default_nettype none

package amu_pkg;

  // Operation codes on the command channel
  localparam logic OP_START = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  // Result kinds
  localparam logic KIND_REQUEST = 1'b0;
  localparam logic KIND_DONE    = 1'b1;

  // Addressing mode codes
  localparam logic [3:0] MODE_IMP = 4'd0;
  localparam logic [3:0] MODE_IMM = 4'd1;
  localparam logic [3:0] MODE_ZP0 = 4'd2;
  localparam logic [3:0] MODE_ZPX = 4'd3;
  localparam logic [3:0] MODE_ZPY = 4'd4;
  localparam logic [3:0] MODE_ABS = 4'd5;
  localparam logic [3:0] MODE_ABX = 4'd6;
  localparam logic [3:0] MODE_ABY = 4'd7;
  localparam logic [3:0] MODE_IND = 4'd8;
  localparam logic [3:0] MODE_IZX = 4'd9;
  localparam logic [3:0] MODE_IZY = 4'd10;
  localparam logic [3:0] MODE_REL = 4'd11;

  // Sequence steps
  localparam logic [1:0] STEP_0 = 2'd0;
  localparam logic [1:0] STEP_1 = 2'd1;
  localparam logic [1:0] STEP_2 = 2'd2;
  localparam logic [1:0] STEP_3 = 2'd3;

  localparam logic [7:0] LOW_LAST = 8'hFF;

  typedef struct packed {
    logic        operation;
    logic [3:0]  mode;
    logic [15:0] pc;
    logic [7:0]  x_index;
    logic [7:0]  y_index;
    logic [7:0]  accumulator;
    logic [7:0]  read_data;
  } amu_item_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] bus_address;
    logic [15:0] effective_address;
    logic [15:0] relative_offset;
    logic [7:0]  fetched_value;
    logic [15:0] next_pc;
    logic        page_crossed;
  } amu_result_t;

  typedef struct packed {
    logic        busy;
    logic [3:0]  cur_mode;
    logic [1:0]  step;
    logic [15:0] saved_pc;
    logic [7:0]  saved_x;
    logic [7:0]  saved_y;
    logic [7:0]  addr_lo;
    logic [7:0]  addr_hi;
  } amu_state_t;

  function automatic amu_result_t amu_request(input logic [15:0] addr);
    amu_result_t r;
    r             = '0;
    r.kind        = KIND_REQUEST;
    r.bus_address = addr;
    return r;
  endfunction

  function automatic amu_result_t amu_done(input logic [15:0] ea,
                                           input logic [15:0] rel,
                                           input logic [7:0]  fv,
                                           input logic [15:0] npc,
                                           input logic        crossed);
    amu_result_t r;
    r                   = '0;
    r.kind              = KIND_DONE;
    r.effective_address = ea;
    r.relative_offset   = rel;
    r.fetched_value     = fv;
    r.next_pc           = npc;
    r.page_crossed      = crossed;
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/amu_cmd_if.sv @@
// ----------------------------------------------------------------------------
// amu_cmd_if
// Command channel: start items and returned bus read data.
// ----------------------------------------------------------------------------
`default_nettype none

interface amu_cmd_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [3:0]  mode;
  logic [15:0] pc;
  logic [7:0]  x_index;
  logic [7:0]  y_index;
  logic [7:0]  accumulator;
  logic [7:0]  read_data;

  modport source (
    output valid, operation, mode, pc, x_index, y_index, accumulator, read_data,
    input  ready
  );
  modport sink (
    input  valid, operation, mode, pc, x_index, y_index, accumulator, read_data,
    output ready
  );
endinterface

`default_nettype wire

@@ design/amu_rsp_if.sv @@
// ----------------------------------------------------------------------------
// amu_rsp_if
// Result channel: bus read requests and addressing-done results.
// ----------------------------------------------------------------------------
`default_nettype none

interface amu_rsp_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] bus_address;
  logic [15:0] effective_address;
  logic [15:0] relative_offset;
  logic [7:0]  fetched_value;
  logic [15:0] next_pc;
  logic        page_crossed;

  modport source (
    output valid, kind, bus_address, effective_address, relative_offset,
           fetched_value, next_pc, page_crossed,
    input  ready
  );
  modport sink (
    input  valid, kind, bus_address, effective_address, relative_offset,
           fetched_value, next_pc, page_crossed,
    output ready
  );
endinterface

`default_nettype wire

@@ design/amu_step.sv @@
// ----------------------------------------------------------------------------
// amu_step
// One sequencer step: next state and optional result for one transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module amu_step (
  input  amu_pkg::amu_item_t   item,
  input  amu_pkg::amu_state_t  st,
  output amu_pkg::amu_state_t  st_next,
  output logic                 res_valid,
  output amu_pkg::amu_result_t res
);

  logic [15:0] pc_inc;
  logic [7:0]  d;
  logic [15:0] base;
  logic [15:0] idx_sum;
  logic [7:0]  idx;
  logic [15:0] ptr_inc;
  logic [15:0] izy_sum;

  // Shared address arithmetic
  always_comb begin
    d       = item.read_data;
    pc_inc  = st.saved_pc + 16'd1;
    base    = {d, st.addr_lo};
    idx     = (st.cur_mode == amu_pkg::MODE_ABX) ? st.saved_x : st.saved_y;
    idx_sum = base + {8'h00, idx};
    ptr_inc = {st.addr_hi, st.addr_lo} + 16'd1;
    izy_sum = base + {8'h00, st.saved_y};
  end

  // Decode the transaction against the current sequence
  always_comb begin
    st_next   = st;
    res_valid = 1'b0;
    res       = '0;
    if (item.operation == amu_pkg::OP_START) begin
      st_next.busy = 1'b0;
      st_next.step = amu_pkg::STEP_0;
      res_valid    = 1'b1;
      if (item.mode == amu_pkg::MODE_IMM) begin
        res = amu_pkg::amu_done(item.pc, 16'h0000, 8'h00, item.pc + 16'd1, 1'b0);
      end else if (item.mode > amu_pkg::MODE_REL || item.mode == amu_pkg::MODE_IMP) begin
        res = amu_pkg::amu_done(16'h0000, 16'h0000, item.accumulator, item.pc, 1'b0);
      end else begin
        st_next.busy     = 1'b1;
        st_next.cur_mode = item.mode;
        st_next.saved_pc = item.pc;
        st_next.saved_x  = item.x_index;
        st_next.saved_y  = item.y_index;
        res              = amu_pkg::amu_request(item.pc);
      end
    end else if (st.busy) begin
      res_valid = 1'b1;
      unique case (st.cur_mode) inside
        amu_pkg::MODE_ZP0: begin
          st_next.saved_pc = pc_inc;
          res = amu_pkg::amu_done({8'h00, d}, 16'h0000, 8'h00, pc_inc, 1'b0);
        end
        amu_pkg::MODE_ZPX: begin
          st_next.saved_pc = pc_inc;
          res = amu_pkg::amu_done({8'h00, d + st.saved_x}, 16'h0000, 8'h00, pc_inc,
                                  1'b0);
        end
        amu_pkg::MODE_ZPY: begin
          st_next.saved_pc = pc_inc;
          res = amu_pkg::amu_done({8'h00, d + st.saved_y}, 16'h0000, 8'h00, pc_inc,
                                  1'b0);
        end
        amu_pkg::MODE_REL: begin
          st_next.saved_pc = pc_inc;
          res = amu_pkg::amu_done(16'h0000, {{8{d[7]}}, d}, 8'h00, pc_inc, 1'b0);
        end
        amu_pkg::MODE_ABS, amu_pkg::MODE_ABX, amu_pkg::MODE_ABY: begin
          st_next.saved_pc = pc_inc;
          if (st.step == amu_pkg::STEP_0) begin
            st_next.addr_lo = d;
            st_next.step    = amu_pkg::STEP_1;
            res             = amu_pkg::amu_request(pc_inc);
          end else begin
            st_next.addr_hi = d;
            if (st.cur_mode == amu_pkg::MODE_ABS) begin
              res = amu_pkg::amu_done(base, 16'h0000, 8'h00, pc_inc, 1'b0);
            end else begin
              res = amu_pkg::amu_done(idx_sum, 16'h0000, 8'h00, pc_inc,
                                      idx_sum[15:8] != d);
            end
          end
        end
        amu_pkg::MODE_IND: begin
          if (st.step == amu_pkg::STEP_0) begin
            st_next.saved_pc = pc_inc;
            st_next.addr_lo  = d;
            st_next.step     = amu_pkg::STEP_1;
            res              = amu_pkg::amu_request(pc_inc);
          end else if (st.step == amu_pkg::STEP_1) begin
            st_next.saved_pc = pc_inc;
            st_next.addr_hi  = d;
            st_next.step     = amu_pkg::STEP_2;
            res              = amu_pkg::amu_request({d, st.addr_lo});
          end else if (st.step == amu_pkg::STEP_2) begin
            // Pointer high byte comes from the same page on a page-end pointer
            st_next.addr_lo = d;
            st_next.step    = amu_pkg::STEP_3;
            if (st.addr_lo == amu_pkg::LOW_LAST) begin
              res = amu_pkg::amu_request({st.addr_hi, 8'h00});
            end else begin
              res = amu_pkg::amu_request(ptr_inc);
            end
          end else begin
            res = amu_pkg::amu_done(base, 16'h0000, 8'h00, st.saved_pc, 1'b0);
          end
        end
        amu_pkg::MODE_IZX: begin
          if (st.step == amu_pkg::STEP_0) begin
            st_next.saved_pc = pc_inc;
            st_next.addr_lo  = d;
            st_next.step     = amu_pkg::STEP_1;
            res              = amu_pkg::amu_request({8'h00, d + st.saved_x});
          end else if (st.step == amu_pkg::STEP_1) begin
            st_next.addr_lo = d;
            st_next.step    = amu_pkg::STEP_2;
            res = amu_pkg::amu_request({8'h00, st.addr_lo + st.saved_x + 8'd1});
          end else begin
            res = amu_pkg::amu_done(base, 16'h0000, 8'h00, st.saved_pc, 1'b0);
          end
        end
        amu_pkg::MODE_IZY: begin
          if (st.step == amu_pkg::STEP_0) begin
            st_next.saved_pc = pc_inc;
            st_next.addr_lo  = d;
            st_next.step     = amu_pkg::STEP_1;
            res              = amu_pkg::amu_request({8'h00, d});
          end else if (st.step == amu_pkg::STEP_1) begin
            st_next.addr_lo = d;
            st_next.step    = amu_pkg::STEP_2;
            res             = amu_pkg::amu_request({8'h00, st.addr_lo + 8'd1});
          end else begin
            res = amu_pkg::amu_done(izy_sum, 16'h0000, 8'h00, st.saved_pc,
                                    izy_sum[15:8] != d);
          end
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
      // A done result closes the sequence
      if (res_valid && res.kind == amu_pkg::KIND_DONE) begin
        st_next.busy = 1'b0;
        st_next.step = amu_pkg::STEP_0;
      end
      if (!res_valid) begin
        st_next.busy = 1'b0;
        st_next.step = amu_pkg::STEP_0;
      end
    end
  end

endmodule

`default_nettype wire

@@ design/cpu6502_address_mode_unit.sv @@
// Path: a command transaction lands in the input register; the result register
//   then loads the sequencer result and offers it until the result channel takes it.
// Throughput: one command transaction per cycle unless a held result stalls the
//   input stage; the sequencer step between the two registers is a short add and
//   mux, so the result register alone paces it.
// Reset: synchronous rst clears both stage valids and the sequencer state.
// ----------------------------------------------------------------------------
// cpu6502_address_mode_unit
// 6502 addressing-mode sequencer: issues operand and pointer reads and
// returns the resolved effective address.
// ----------------------------------------------------------------------------
`default_nettype none

module cpu6502_address_mode_unit (
  input  wire logic clk,
  input  wire logic rst,
  amu_cmd_if.sink   cmd,
  amu_rsp_if.source rsp
);

  logic                 s1_valid;
  amu_pkg::amu_item_t   s1_item;
  amu_pkg::amu_item_t   cmd_item;
  logic                 s1_adv;
  amu_pkg::amu_state_t  st;
  amu_pkg::amu_state_t  st_next;
  logic                 res_valid;
  amu_pkg::amu_result_t res;
  logic                 out_valid;
  amu_pkg::amu_result_t out_res;
  logic                 st_step3;
  logic                 st_ind;
  logic                 st_mode_ok;
  logic                 all_idle;

  // Gather the command payload
  always_comb begin
    cmd_item.operation   = cmd.operation;
    cmd_item.mode        = cmd.mode;
    cmd_item.pc          = cmd.pc;
    cmd_item.x_index     = cmd.x_index;
    cmd_item.y_index     = cmd.y_index;
    cmd_item.accumulator = cmd.accumulator;
    cmd_item.read_data   = cmd.read_data;
  end

  amu_step u_step (
    .item      (s1_item),
    .st        (st),
    .st_next   (st_next),
    .res_valid (res_valid),
    .res       (res)
  );

  // Advance the input stage when it yields no result or its result has somewhere to go
  assign s1_adv    = !res_valid || !out_valid || rsp.ready;
  assign cmd.ready = !s1_valid || s1_adv;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.ready) begin
      s1_valid <= cmd.valid;
    end
    if (cmd.ready && cmd.valid) begin
      s1_item <= cmd_item;
    end
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (s1_valid && s1_adv) begin
      st <= st_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_valid && s1_adv && res_valid) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (s1_valid && s1_adv && res_valid) begin
      out_res <= res;
    end
  end

  assign rsp.valid             = out_valid;
  assign rsp.kind              = out_res.kind;
  assign rsp.bus_address       = out_res.bus_address;
  assign rsp.effective_address = out_res.effective_address;
  assign rsp.relative_offset   = out_res.relative_offset;
  assign rsp.fetched_value     = out_res.fetched_value;
  assign rsp.next_pc           = out_res.next_pc;
  assign rsp.page_crossed      = out_res.page_crossed;

  // Terms for the checks below
  assign st_step3   = (st.step == amu_pkg::STEP_3);
  assign st_ind     = (st.cur_mode == amu_pkg::MODE_IND);
  assign st_mode_ok = (st.cur_mode >= amu_pkg::MODE_ZP0) &&
                      (st.cur_mode <= amu_pkg::MODE_REL);
  assign all_idle   = !st.busy && !out_valid && !s1_valid;

`include "cpu6502_address_mode_unit_macros.svh"

  `AMU_ASSERT(a_step_needs_busy, (st.step != amu_pkg::STEP_0) |-> st.busy, "step set while idle")
  `AMU_ASSERT(a_step3_is_ind, st_step3 |-> st_ind, "step 3 outside IND")
  `AMU_ASSERT(a_busy_mode, st.busy |-> st_mode_ok, "busy with a non-sequenced mode")
  `AMU_ASSERT(a_s1_hold, (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1_item)), "item lost")
  `AMU_ASSERT_ALWAYS(a_reset_idle, $past(rst) |-> all_idle, "not idle after reset")

endmodule

`default_nettype wire

@@ tb/cpu6502_address_mode_unit_tb.sv @@
// ----------------------------------------------------------------------------
// cpu6502_address_mode_unit_tb
// Streams start and read-data transactions into the addressing-mode unit.
// A behavioral copy of the sequencer, or a fixed expectation on some directed rows,
// predicts every bus request and done result; each is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module cpu6502_address_mode_unit_tb;
  import amu_pkg::*;

  localparam int CLK_PERIOD     = 8;
  localparam int RANDOM_ITEMS   = 1500;
  localparam int QUIET_TAIL     = 200;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 8;

  typedef struct {
    amu_item_t   item;
    bit          fixed;
    bit          fixed_emits;
    amu_result_t fixed_res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;

  amu_cmd_if cmd_ch ();
  amu_rsp_if rsp_ch ();

  cpu6502_address_mode_unit i_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Sequencer shadow state
  logic        seq_busy;
  logic [3:0]  seq_mode;
  logic [1:0]  seq_step;
  logic [15:0] seq_pc;
  logic [7:0]  seq_x;
  logic [7:0]  seq_y;
  logic [7:0]  seq_lo;
  logic [7:0]  seq_hi;

  amu_result_t addr_results_due[$];
  dir_row_t    directed[$];

  bit idle_en;
  bit long_hold_req;
  int hold_left;
  int quiet_cycles;
  int fed;
  int ignored;
  int results_seen;
  int mismatches;
  int mode_starts[16];

  function automatic amu_result_t bus_read(input logic [15:0] addr);
    return {KIND_REQUEST, addr, 16'h0000, 16'h0000, 8'h00, 16'h0000, 1'b0};
  endfunction

  function automatic amu_result_t resolved(input logic [15:0] ea, input logic [15:0] rel,
                                           input logic [7:0] fv, input logic [15:0] npc,
                                           input logic crossed);
    return {KIND_DONE, 16'h0000, ea, rel, fv, npc, crossed};
  endfunction

  // Bias toward boundary values a quarter of the time
  function automatic logic [7:0] pick_byte();
    logic [7:0] edges[4] = '{8'h00, 8'hFF, 8'h80, 8'h7F};
    if ($urandom_range(0, 3) == 0) return edges[$urandom_range(0, 3)];
    return 8'($urandom);
  endfunction

  function automatic logic [15:0] pick_word();
    logic [15:0] edges[5] = '{16'h0000, 16'hFFFF, 16'h00FF, 16'hFF00, 16'hFFFE};
    if ($urandom_range(0, 3) == 0) return edges[$urandom_range(0, 4)];
    return 16'($urandom);
  endfunction

  function automatic amu_item_t start_item(input logic [3:0] mode, input logic [15:0] pc,
                                           input logic [7:0] x, input logic [7:0] y,
                                           input logic [7:0] acc);
    amu_item_t it;
    it.operation   = OP_START;
    it.mode        = mode;
    it.pc          = pc;
    it.x_index     = x;
    it.y_index     = y;
    it.accumulator = acc;
    it.read_data   = 8'($urandom);
    return it;
  endfunction

  // Fields other than read_data are don't-care on a data transaction
  function automatic amu_item_t data_item(input logic [7:0] d);
    amu_item_t it;
    it             = amu_item_t'({$urandom, $urandom, $urandom});
    it.operation   = OP_DATA;
    it.read_data   = d;
    return it;
  endfunction

  function automatic int operand_reads(input logic [3:0] mode);
    case (mode)
      MODE_ZP0, MODE_ZPX, MODE_ZPY, MODE_REL: return 1;
      MODE_ABS, MODE_ABX, MODE_ABY:           return 2;
      MODE_IZX, MODE_IZY:                     return 3;
      MODE_IND:                               return 4;
      default:                                return 0;
    endcase
  endfunction

  // Advance the shadow sequencer by one accepted transaction
  task automatic resolve_addressing(input amu_item_t it, output bit emits,
                                    output amu_result_t res);
    logic [7:0]  d;
    logic [7:0]  zp;
    logic [15:0] ea;
    logic [15:0] ptr;
    d     = it.read_data;
    emits = 1'b1;
    res   = '0;
    if (it.operation == OP_START) begin
      seq_busy = 1'b0;
      seq_step = STEP_0;
      if (it.mode == MODE_IMM) begin
        res = resolved(it.pc, 16'h0000, 8'h00, it.pc + 16'd1, 1'b0);
      end else if (it.mode == MODE_IMP || it.mode > MODE_REL) begin
        res = resolved(16'h0000, 16'h0000, it.accumulator, it.pc, 1'b0);
      end else begin
        seq_busy = 1'b1;
        seq_mode = it.mode;
        seq_pc   = it.pc;
        seq_x    = it.x_index;
        seq_y    = it.y_index;
        res      = bus_read(it.pc);
      end
    end else if (!seq_busy) begin
      emits = 1'b0;
    end else begin
      case (seq_mode)
        MODE_ZP0, MODE_ZPX, MODE_ZPY: begin
          seq_pc = seq_pc + 16'd1;
          zp = d + ((seq_mode == MODE_ZPX) ? seq_x : (seq_mode == MODE_ZPY) ? seq_y : 8'h00);
          res = resolved({8'h00, zp}, 16'h0000, 8'h00, seq_pc, 1'b0);
        end
        MODE_REL: begin
          seq_pc = seq_pc + 16'd1;
          res = resolved(16'h0000, {{8{d[7]}}, d}, 8'h00, seq_pc, 1'b0);
        end
        MODE_ABS, MODE_ABX, MODE_ABY: begin
          seq_pc = seq_pc + 16'd1;
          if (seq_step == STEP_0) begin
            seq_lo   = d;
            seq_step = STEP_1;
            res      = bus_read(seq_pc);
          end else begin
            seq_hi = d;
            if (seq_mode == MODE_ABS) begin
              res = resolved({seq_hi, seq_lo}, 16'h0000, 8'h00, seq_pc, 1'b0);
            end else begin
              ea  = {seq_hi, seq_lo} + {8'h00, (seq_mode == MODE_ABX) ? seq_x : seq_y};
              res = resolved(ea, 16'h0000, 8'h00, seq_pc, ea[15:8] != seq_hi);
            end
          end
        end
        MODE_IND: begin
          case (seq_step)
            STEP_0: begin
              seq_pc   = seq_pc + 16'd1;
              seq_lo   = d;
              seq_step = STEP_1;
              res      = bus_read(seq_pc);
            end
            STEP_1: begin
              seq_pc   = seq_pc + 16'd1;
              seq_hi   = d;
              seq_step = STEP_2;
              res      = bus_read({seq_hi, seq_lo});
            end
            STEP_2: begin
              // Pointer at the end of a page wraps to the start of the same page
              ptr      = {seq_hi, seq_lo};
              ptr      = (seq_lo == LOW_LAST) ? {seq_hi, 8'h00} : ptr + 16'd1;
              seq_lo   = d;
              seq_step = STEP_3;
              res      = bus_read(ptr);
            end
            default: begin
              res = resolved({d, seq_lo}, 16'h0000, 8'h00, seq_pc, 1'b0);
            end
          endcase
        end
        MODE_IZX: begin
          if (seq_step == STEP_0) begin
            seq_pc   = seq_pc + 16'd1;
            seq_lo   = d;
            seq_step = STEP_1;
            zp       = d + seq_x;
            res      = bus_read({8'h00, zp});
          end else if (seq_step == STEP_1) begin
            zp       = seq_lo + seq_x + 8'd1;
            seq_lo   = d;
            seq_step = STEP_2;
            res      = bus_read({8'h00, zp});
          end else begin
            res = resolved({d, seq_lo}, 16'h0000, 8'h00, seq_pc, 1'b0);
          end
        end
        MODE_IZY: begin
          if (seq_step == STEP_0) begin
            seq_pc   = seq_pc + 16'd1;
            seq_lo   = d;
            seq_step = STEP_1;
            res      = bus_read({8'h00, d});
          end else if (seq_step == STEP_1) begin
            zp       = seq_lo + 8'd1;
            seq_lo   = d;
            seq_step = STEP_2;
            res      = bus_read({8'h00, zp});
          end else begin
            ea  = {d, seq_lo} + {8'h00, seq_y};
            res = resolved(ea, 16'h0000, 8'h00, seq_pc, ea[15:8] != d);
          end
        end
        default: begin
          seq_busy = 1'b0;
          seq_step = STEP_0;
          emits    = 1'b0;
        end
      endcase
    end
    // A done result closes the sequence
    if (emits && res.kind == KIND_DONE) begin
      seq_busy = 1'b0;
      seq_step = STEP_0;
    end
  endtask

  // Offer one transaction, wait for the handshake, then record its expectation
  task automatic send_cmd(input amu_item_t it, input bit fixed, input bit fixed_emits,
                          input amu_result_t fixed_res);
    bit          emits;
    amu_result_t res;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    cmd_ch.valid       <= 1'b1;
    cmd_ch.operation   <= it.operation;
    cmd_ch.mode        <= it.mode;
    cmd_ch.pc          <= it.pc;
    cmd_ch.x_index     <= it.x_index;
    cmd_ch.y_index     <= it.y_index;
    cmd_ch.accumulator <= it.accumulator;
    cmd_ch.read_data   <= it.read_data;
    do @(posedge clk); while (!cmd_ch.ready);
    resolve_addressing(it, emits, res);
    if (fixed) begin
      emits = fixed_emits;
      res   = fixed_res;
    end
    if (emits) begin
      addr_results_due.push_back(res);
      fed++;
    end else begin
      ignored++;
    end
    if (it.operation == OP_START) mode_starts[it.mode]++;
  endtask

  task automatic add_row(input amu_item_t it, input bit fixed, input bit fixed_emits,
                         input amu_result_t fixed_res);
    dir_row_t row;
    row.item        = it;
    row.fixed       = fixed;
    row.fixed_emits = fixed_emits;
    row.fixed_res   = fixed_res;
    directed.push_back(row);
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %h, actual %h", name, want, got);
      mismatches++;
    end
  endtask

  // Compare each result transaction against the oldest expectation
  always @(posedge clk) begin
    amu_result_t got;
    amu_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got = {rsp_ch.kind, rsp_ch.bus_address, rsp_ch.effective_address,
             rsp_ch.relative_offset, rsp_ch.fetched_value, rsp_ch.next_pc,
             rsp_ch.page_crossed};
      results_seen++;
      if (addr_results_due.size() == 0) begin
        $error("unexpected result: kind %0d bus_address %h effective_address %h",
               got.kind, got.bus_address, got.effective_address);
        mismatches++;
      end else begin
        want = addr_results_due.pop_front();
        check_field("kind", want.kind, got.kind);
        check_field("bus_address", want.bus_address, got.bus_address);
        check_field("effective_address", want.effective_address, got.effective_address);
        check_field("relative_offset", want.relative_offset, got.relative_offset);
        check_field("fetched_value", want.fetched_value, got.fetched_value);
        check_field("next_pc", want.next_pc, got.next_pc);
        check_field("page_crossed", want.page_crossed, got.page_crossed);
      end
    end
  end

  // Abort when neither channel moves a transaction for too long
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("cpu6502_address_mode_unit_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result-side backpressure: random bursts plus one long hold
  initial begin
    bit hold_taken;
    hold_taken = 1'b0;
    rsp_ch.ready <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (long_hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        hold_left = $urandom_range(0, 6);
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    amu_item_t   it;
    logic [3:0]  m;
    int          reads;
    int          r;
    int          random_base;
    int          progress;
    bit          held;
    amu_result_t none;

    none          = '0;
    held          = 1'b0;
    idle_en       = 1'b1;
    long_hold_req = 1'b0;
    seq_busy      = 1'b0;
    seq_mode      = MODE_IMP;
    seq_step      = STEP_0;
    seq_pc        = '0;
    seq_x         = '0;
    seq_y         = '0;
    seq_lo        = '0;
    seq_hi        = '0;

    rst                <= 1'b1;
    cmd_ch.valid       <= 1'b0;
    cmd_ch.operation   <= OP_START;
    cmd_ch.mode        <= MODE_IMP;
    cmd_ch.pc          <= '0;
    cmd_ch.x_index     <= '0;
    cmd_ch.y_index     <= '0;
    cmd_ch.accumulator <= '0;
    cmd_ch.read_data   <= '0;

    // Directed stimulus; fixed expectations where they are obvious
    add_row(data_item(8'h5A), 1, 0, none);                              // data while idle
    add_row(start_item(MODE_IMP, 16'hFFFF, 8'h00, 8'h00, 8'hFF), 1, 1,
            resolved(16'h0000, 16'h0000, 8'hFF, 16'hFFFF, 1'b0));
    add_row(start_item(MODE_IMM, 16'hFFFF, 8'hFF, 8'hFF, 8'h00), 1, 1,
            resolved(16'hFFFF, 16'h0000, 8'h00, 16'h0000, 1'b0));      // pc wraps
    add_row(start_item(4'd15, 16'h1234, 8'h11, 8'h22, 8'h5A), 1, 1,
            resolved(16'h0000, 16'h0000, 8'h5A, 16'h1234, 1'b0));      // unused code
    add_row(start_item(MODE_ZPX, 16'h0200, 8'hFF, 8'h00, 8'h00), 1, 1, bus_read(16'h0200));
    add_row(data_item(8'hFF), 0, 0, none);                              // zero page wrap
    add_row(start_item(MODE_REL, 16'hFFFF, 8'h00, 8'h00, 8'h00), 1, 1, bus_read(16'hFFFF));
    add_row(data_item(8'h80), 0, 0, none);                              // negative offset
    add_row(start_item(MODE_ABX, 16'h10FE, 8'hFF, 8'h00, 8'h00), 0, 0, none);
    add_row(data_item(8'hFF), 0, 0, none);
    add_row(data_item(8'hFF), 0, 0, none);                              // 16-bit wrap, crossed
    add_row(start_item(MODE_IND, 16'h3000, 8'h00, 8'h00, 8'h00), 0, 0, none);
    add_row(data_item(8'hFF), 0, 0, none);
    add_row(data_item(8'h12), 0, 0, none);
    add_row(data_item(8'h34), 0, 0, none);                              // page-wrap pointer
    add_row(data_item(8'h56), 0, 0, none);
    add_row(start_item(MODE_IZY, 16'h0400, 8'h00, 8'hFF, 8'h00), 0, 0, none);
    add_row(data_item(8'hFF), 0, 0, none);
    add_row(data_item(8'hFF), 0, 0, none);
    add_row(data_item(8'h00), 0, 0, none);
    add_row(start_item(MODE_ABS, 16'hFFFF, 8'h00, 8'h00, 8'h00), 0, 0, none);
    add_row(data_item(8'h00), 0, 0, none);
    add_row(start_item(MODE_IZX, 16'h0000, 8'h80, 8'h00, 8'h00), 0, 0, none); // drops ABS
    add_row(data_item(8'h80), 0, 0, none);
    add_row(data_item(8'h11), 0, 0, none);
    add_row(data_item(8'h22), 0, 0, none);
    add_row(data_item(8'hA5), 1, 0, none);                              // idle again

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      send_cmd(directed[i].item, directed[i].fixed, directed[i].fixed_emits,
               directed[i].fixed_res);
    end

    // Random sequences: mostly complete, some cut short, some stray data
    random_base = fed;
    progress    = 0;
    while (progress < RANDOM_ITEMS) begin
      idle_en = (progress < RANDOM_ITEMS - QUIET_TAIL) && ((progress / 150) % 4 != 3);
      if (!held && progress >= 500) begin
        long_hold_req = 1'b1;
        held          = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 8) begin
        send_cmd(data_item(pick_byte()), 0, 0, none);
      end else if (r < 16) begin
        m = $urandom_range(0, 1) ? 4'($urandom_range(12, 15)) : 4'($urandom_range(0, 1));
        send_cmd(start_item(m, pick_word(), pick_byte(), pick_byte(), pick_byte()), 0, 0,
                 none);
      end else begin
        m     = 4'($urandom_range(MODE_ZP0, MODE_REL));
        reads = operand_reads(m);
        if (r >= 88) reads = $urandom_range(0, reads - 1);
        send_cmd(start_item(m, pick_word(), pick_byte(), pick_byte(), pick_byte()), 0, 0,
                 none);
        repeat (reads) send_cmd(data_item(pick_byte()), 0, 0, none);
      end
      progress = fed - random_base;
    end

    // Drain outstanding results
    idle_en = 1'b0;
    cmd_ch.valid <= 1'b0;
    while (addr_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d result-bearing and %0d ignored transactions; %0d checked, %0d bad.",
             fed, ignored, results_seen, mismatches);
    $display("Starts per mode IMP..REL: %0d %0d %0d %0d %0d %0d %0d %0d %0d %0d %0d %0d",
             mode_starts[0], mode_starts[1], mode_starts[2], mode_starts[3],
             mode_starts[4], mode_starts[5], mode_starts[6], mode_starts[7],
             mode_starts[8], mode_starts[9], mode_starts[10], mode_starts[11]);
    $display("Starts with unused codes: %0d",
             mode_starts[12] + mode_starts[13] + mode_starts[14] + mode_starts[15]);
    if (mismatches == 0) begin
      $display("cpu6502_address_mode_unit_tb: PASS");
    end else begin
      $display("cpu6502_address_mode_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
